[rtl/ptts_pkg.sv]
// Shared types and constants of the periodic task tick scheduler.
`timescale 1ns / 1ps

package ptts_pkg;

	localparam int unsigned SLOT_W = 8;
	localparam int unsigned TIME_W = 16;
	localparam int unsigned DUE_W = 3;
	localparam int unsigned MAX_RESULTS = 8;
	localparam int unsigned RCNT_W = 4;

	typedef enum logic [1:0] {
		KIND_CREATE = 2'd0,
		KIND_DUE    = 2'd1,
		KIND_NONE   = 2'd2
	} kind_t;

	typedef enum logic {
		STATUS_OK  = 1'b0,
		STATUS_BAD = 1'b1
	} status_t;

	typedef enum logic {
		CMD_TICK   = 1'b0,
		CMD_CREATE = 1'b1
	} cmd_t;

	// controller -> datapath
	typedef struct packed {
		logic start_create;
		logic start_tick;
		logic step;
		logic fin;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_push;
		logic out_free;
		logic scan_done;
	} dp_status_t;

endpackage

[rtl/ptts_ctrl.sv]
// Sequencing state machine of the scheduler: idle, slot scan, final beat.
`timescale 1ns / 1ps

module ptts_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   cmd,
	output logic                   in_stall,
	input  ptts_pkg::dp_status_t   dp_sts,
	output ptts_pkg::ctl_cmd_t     ctl
);
	import ptts_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d          = state_q;
		in_stall         = 1'b1;
		ctl.start_create = 1'b0;
		ctl.start_tick   = 1'b0;
		ctl.step         = 1'b0;
		ctl.fin          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (cmd == CMD_CREATE) begin
						ctl.start_create = 1'b1;
						state_d          = ST_FIN;
					end else begin
						ctl.start_tick = 1'b1;
						state_d        = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (dp_sts.scan_done) begin
					state_d = ST_FIN;
				end else begin
					// hold the scan while a due beat cannot leave
					ctl.step = !(dp_sts.need_push && !dp_sts.out_free);
				end
			end
			ST_FIN: begin
				if (dp_sts.out_free) begin
					ctl.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_step_only_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> (state_q == ST_SCAN))
		else $error("scan step outside scan");

	a_fin_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |=> (state_q == ST_IDLE))
		else $error("final beat did not return to idle");

	a_create_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start_create |=> (state_q == ST_FIN))
		else $error("create did not go to final beat");

endmodule

[rtl/ptts_datapath.sv]
// Timer memories, live flags, scan pipeline and output register.
`timescale 1ns / 1ps

module ptts_datapath #(
	parameter int unsigned MAX_TASKS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ptts_pkg::ctl_cmd_t              ctl,
	output ptts_pkg::dp_status_t            dp_sts,
	input  logic [ptts_pkg::SLOT_W-1:0]     task_slot,
	input  logic [ptts_pkg::TIME_W-1:0]     period_ticks,
	input  logic [ptts_pkg::TIME_W-1:0]     first_delay,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      kind,
	output logic [ptts_pkg::DUE_W-1:0]      due_slot,
	output logic                            status,
	output logic                            last
);
	import ptts_pkg::*;

	localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned CW = $clog2(MAX_TASKS + 1);

	logic [TIME_W-1:0] cd_mem [MAX_TASKS];
	logic [TIME_W-1:0] rp_mem [MAX_TASKS];
	logic [MAX_TASKS-1:0] live_q;

	logic [CW-1:0]     rd_idx_q;
	logic              valid_s1;
	logic [IW-1:0]     idx_s1;
	logic [TIME_W-1:0] cd_s1;
	logic [TIME_W-1:0] rp_s1;

	logic              pend_valid_q;
	logic [DUE_W-1:0]  pend_slot_q;
	logic [RCNT_W-1:0] rcnt_q;
	logic              is_create_q;
	logic              bad_q;

	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [DUE_W-1:0]  due_slot_q;
	logic              status_q;
	logic              last_q;

	logic              slot_ok;
	logic              rd_en;
	logic              s1_live;
	logic              s1_due;
	logic              s1_report;
	logic              push;
	logic              out_free;
	logic              mem_we;
	logic [IW-1:0]     wr_addr;
	logic [TIME_W-1:0] wr_cd;
	logic [IW+DUE_W-1:0] idx_ext;

	assign slot_ok   = ({1'b0, task_slot} < (SLOT_W + 1)'(MAX_TASKS));
	assign rd_en     = ctl.step && (rd_idx_q < CW'(MAX_TASKS));
	assign s1_live   = valid_s1 && live_q[idx_s1];
	assign s1_due    = s1_live && (cd_s1 == '0);
	assign s1_report = s1_due && (rcnt_q < RCNT_W'(MAX_RESULTS));
	assign push      = ctl.step && s1_report && pend_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign idx_ext   = {{DUE_W{1'b0}}, idx_s1};

	assign dp_sts.need_push = s1_report && pend_valid_q;
	assign dp_sts.out_free  = out_free;
	assign dp_sts.scan_done = !valid_s1 && (rd_idx_q == CW'(MAX_TASKS));

	// single write port: create at accept, countdown write-back during scan
	always_comb begin
		mem_we  = 1'b0;
		wr_addr = idx_s1;
		wr_cd   = cd_s1 - 1'b1;
		if (ctl.start_create) begin
			mem_we  = slot_ok;
			wr_addr = task_slot[IW-1:0];
			wr_cd   = first_delay;
		end else if (ctl.step && s1_live) begin
			mem_we = 1'b1;
			if (s1_due) begin
				wr_cd = rp_s1 - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cd_mem[wr_addr] <= wr_cd;
		end
		if (ctl.start_create && slot_ok) begin
			rp_mem[wr_addr] <= period_ticks;
		end
		if (rd_en) begin
			cd_s1 <= cd_mem[rd_idx_q[IW-1:0]];
			rp_s1 <= rp_mem[rd_idx_q[IW-1:0]];
		end
		if (ctl.step) begin
			idx_s1 <= rd_idx_q[IW-1:0];
		end
		if (ctl.start_create) begin
			bad_q <= !slot_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q       <= '0;
			rd_idx_q     <= '0;
			valid_s1     <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_slot_q  <= '0;
			rcnt_q       <= '0;
			is_create_q  <= 1'b0;
		end else begin
			if (ctl.start_create) begin
				is_create_q <= 1'b1;
				if (slot_ok) begin
					live_q[task_slot[IW-1:0]] <= 1'b1;
				end
			end
			if (ctl.start_tick) begin
				is_create_q  <= 1'b0;
				rd_idx_q     <= '0;
				valid_s1     <= 1'b0;
				pend_valid_q <= 1'b0;
				rcnt_q       <= '0;
			end
			if (ctl.step) begin
				valid_s1 <= rd_en;
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (s1_report) begin
					pend_valid_q <= 1'b1;
					pend_slot_q  <= idx_ext[DUE_W-1:0];
					rcnt_q       <= rcnt_q + 1'b1;
				end
			end
		end
	end

	// output register: earlier due beats leave with last low, the final beat
	// is built once the scan has drained, or straight after a create
	always_ff @(posedge clk) begin
		if (push) begin
			kind_q     <= KIND_DUE;
			due_slot_q <= pend_slot_q;
			status_q   <= STATUS_OK;
			last_q     <= 1'b0;
		end else if (ctl.fin) begin
			last_q <= 1'b1;
			if (is_create_q) begin
				kind_q     <= KIND_CREATE;
				due_slot_q <= '0;
				status_q   <= bad_q ? STATUS_BAD : STATUS_OK;
			end else if (pend_valid_q) begin
				kind_q     <= KIND_DUE;
				due_slot_q <= pend_slot_q;
				status_q   <= STATUS_OK;
			end else begin
				kind_q     <= KIND_NONE;
				due_slot_q <= '0;
				status_q   <= STATUS_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push || ctl.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign due_slot  = due_slot_q;
	assign status    = status_q;
	assign last      = last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(push || ctl.fin) |-> out_free)
		else $error("output beat overwritten while stalled");

	a_rcnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= RCNT_W'(MAX_RESULTS))
		else $error("due report count beyond cap");

	a_pend_matches_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q == (rcnt_q != '0))
		else $error("pending due beat out of step with count");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ({1'b0, idx_s1} < (IW + 1)'(MAX_TASKS)))
		else $error("scan index beyond slot count");

endmodule

[rtl/periodic_task_tick_scheduler_top.sv]
// Top level of the periodic task tick scheduler: controller plus datapath.
// Create: accepted in idle, its single beat is loaded into the output register from the final-beat state.
// Tick: one slot visited per cycle through the countdown memory read port, except while
//   a held due beat waits on a stalled output register.
// One input beat is worked on at a time; in_stall is high from acceptance until
//   the final result beat has been loaded into the output register.
// Reset (arst_n low, asynchronous): all slots idle, no result pending, controller idle.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_top #(
	parameter int unsigned MAX_TASKS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [ptts_pkg::SLOT_W-1:0] task_slot,
	input  logic [ptts_pkg::TIME_W-1:0] period_ticks,
	input  logic [ptts_pkg::TIME_W-1:0] first_delay,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  kind,
	output logic [ptts_pkg::DUE_W-1:0]  due_slot,
	output logic                        status,
	output logic                        last
);
	import ptts_pkg::*;

	// command and status between the sequencer and the datapath
	ctl_cmd_t   ctl;
	dp_status_t dp_sts;

	// The sequencer accepts one beat in idle. A create goes straight to the
	// final beat; a tick runs the slot scan first.
	ptts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.dp_sts   (dp_sts),
		.ctl      (ctl)
	);

	// The datapath holds the countdown and period memories and the live flags.
	// During a scan a slot is read into the stage-1 registers and written back from
	// them, so the read and write addresses never meet. Each due slot is held back
	// by one report so that the last one can carry the last flag; the scan
	// pauses while a held report cannot enter a stalled output register.
	ptts_datapath #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.dp_sts       (dp_sts),
		.task_slot    (task_slot),
		.period_ticks (period_ticks),
		.first_delay  (first_delay),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.due_slot     (due_slot),
		.status       (status),
		.last         (last)
	);

endmodule

[tb/periodic_task_tick_scheduler_top_tb.sv]
// Self-checking testbench for the periodic task tick scheduler top level.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_top_tb;
	import ptts_pkg::*;

	localparam int unsigned N_SLOTS = 8;

	// one request beat as the driver presents it
	typedef struct {
		cmd_t                cmd;
		logic [SLOT_W-1:0]   slot;
		logic [TIME_W-1:0]   period;
		logic [TIME_W-1:0]   delay;
	} sched_req_t;

	// one result beat as the scheduler should return it
	typedef struct {
		kind_t               kind;
		logic [DUE_W-1:0]    due_slot;
		status_t             status;
		logic                last;
	} sched_report_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                cmd = CMD_TICK;
	logic [SLOT_W-1:0]   task_slot = '0;
	logic [TIME_W-1:0]   period_ticks = '0;
	logic [TIME_W-1:0]   first_delay = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          kind;
	logic [DUE_W-1:0]    due_slot;
	logic                status;
	logic                last;

	sched_req_t          pending_reqs[$];
	sched_report_t       awaited_reports[$];
	int                  total_reqs;
	int                  beats_taken = 0;
	int                  mismatches = 0;
	logic                steady_run;

	// shadow of the timer bank: live flags, countdowns and reload periods
	logic                slot_armed [N_SLOTS];
	logic [TIME_W-1:0]   count_left [N_SLOTS];
	logic [TIME_W-1:0]   reload_len [N_SLOTS];

	periodic_task_tick_scheduler_top #(
		.MAX_TASKS(N_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.task_slot(task_slot),
		.period_ticks(period_ticks),
		.first_delay(first_delay),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.due_slot(due_slot),
		.status(status),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// A stretch of about a hundred beats in the middle of the run with no
	// idling on either side, so back-to-back traffic is seen as well.
	assign steady_run = (beats_taken >= 140) && (beats_taken < 240);

	// Work out the results that one accepted beat must produce, and move the
	// shadow timer bank on. Slots that were never created are skipped, so
	// their undefined countdowns are never looked at.
	task automatic advance_schedule(input sched_req_t rq);
		sched_report_t     rep;
		logic [N_SLOTS-1:0] due_mask;
		int unsigned       n_due;
		due_mask = '0;
		n_due = 0;
		rep.kind = KIND_CREATE;
		rep.due_slot = '0;
		rep.status = STATUS_OK;
		rep.last = 1'b1;
		if (rq.cmd == CMD_CREATE) begin
			if (rq.slot < N_SLOTS) begin
				// a live slot is simply overwritten
				slot_armed[rq.slot] = 1'b1;
				count_left[rq.slot] = rq.delay;
				reload_len[rq.slot] = rq.period;
			end else begin
				rep.status = STATUS_BAD;
			end
			awaited_reports.push_back(rep);
		end else begin
			for (int s = 0; s < N_SLOTS; s++) begin
				if (slot_armed[s]) begin
					if (count_left[s] == '0) begin
						// a zero period wraps round to the full count
						due_mask[s] = 1'b1;
						count_left[s] = reload_len[s] - 1'b1;
					end else begin
						count_left[s] = count_left[s] - 1'b1;
					end
				end
			end
			if (due_mask == '0) begin
				rep.kind = KIND_NONE;
				awaited_reports.push_back(rep);
			end else begin
				// one beat per due slot in index order, capped at the burst limit
				rep.kind = KIND_DUE;
				for (int s = 0; s < N_SLOTS; s++) begin
					if (due_mask[s] && n_due < MAX_RESULTS) begin
						rep.due_slot = DUE_W'(s);
						rep.last = (n_due + 1 == MAX_RESULTS) ||
							((due_mask >> (s + 1)) == '0);
						awaited_reports.push_back(rep);
						n_due++;
					end
				end
			end
		end
	endtask

	task automatic queue_req(input cmd_t c, input int unsigned slot,
			input int unsigned period, input int unsigned delay);
		sched_req_t rq;
		rq.cmd = c;
		rq.slot = SLOT_W'(slot);
		rq.period = TIME_W'(period);
		rq.delay = TIME_W'(delay);
		pending_reqs.push_back(rq);
	endtask

	task automatic check_field(input string name, input logic [DUE_W-1:0] want,
			input logic [DUE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Driver: presents the next queued beat once the current one is taken,
	// idling now and then; a stalled beat is held unchanged.
	always @(posedge clk or negedge arst_n) begin
		sched_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending_reqs.size() > 0 && (steady_run || $urandom_range(99) >= 20)) begin
				nxt = pending_reqs.pop_front();
				in_valid <= 1'b1;
				cmd <= nxt.cmd;
				task_slot <= nxt.slot;
				period_ticks <= nxt.period;
				first_delay <= nxt.delay;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure, off during the steady stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= !steady_run && ($urandom_range(99) < 20);
	end

	// Every accepted request beat feeds the prediction.
	always @(posedge clk) begin
		sched_req_t rq;
		if (arst_n && in_valid && !in_stall) begin
			rq.cmd = cmd_t'(cmd);
			rq.slot = task_slot;
			rq.period = period_ticks;
			rq.delay = first_delay;
			advance_schedule(rq);
			beats_taken <= beats_taken + 1;
		end
	end

	// Monitor: each accepted result beat against the oldest prediction.
	always @(posedge clk) begin
		sched_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_reports.size() == 0) begin
				$error("unexpected result beat: kind %0d, due_slot %0d", kind, due_slot);
				mismatches++;
			end else begin
				want = awaited_reports.pop_front();
				check_field("kind", DUE_W'(want.kind), DUE_W'(kind));
				check_field("due_slot", want.due_slot, due_slot);
				check_field("status", DUE_W'(want.status), DUE_W'(status));
				check_field("last", DUE_W'(want.last), DUE_W'(last));
			end
		end
	end

	initial begin
		int unsigned c;
		for (int s = 0; s < N_SLOTS; s++) begin
			slot_armed[s] = 1'b0;
			count_left[s] = '0;
			reload_len[s] = '0;
		end

		// Directed opening: empty tick (other fields ignored but fully set),
		// bad slots, zero period, overwrite of a live slot, all slots due at once.
		queue_req(CMD_TICK, 255, 16'hFFFF, 16'hFFFF);
		queue_req(CMD_CREATE, 8, 5, 5);
		queue_req(CMD_CREATE, 255, 16'hFFFF, 16'hFFFF);
		queue_req(CMD_CREATE, 128, 16'h5555, 16'hAAAA);
		queue_req(CMD_CREATE, 0, 0, 0);
		queue_req(CMD_TICK, 0, 0, 0);
		queue_req(CMD_TICK, 0, 0, 0);
		queue_req(CMD_CREATE, 7, 16'hFFFF, 16'hFFFF);
		queue_req(CMD_CREATE, 0, 2, 0);
		queue_req(CMD_CREATE, 1, 1, 0);
		for (int s = 2; s < 7; s++)
			queue_req(CMD_CREATE, s, 3, 0);
		queue_req(CMD_CREATE, 7, 1, 0);
		for (int k = 0; k < 4; k++)
			queue_req(CMD_TICK, 16'hAA, 16'h5555, 16'hAAAA);

		// Random part: mostly sane creates with short periods and delays so
		// tasks fall due often, with bad slots and full-range values mixed in.
		for (int k = 0; k < 420; k++) begin
			c = $urandom_range(99);
			if (c < 30) begin
				queue_req(CMD_CREATE,
					($urandom_range(9) == 0) ? $urandom_range(255, N_SLOTS)
						: $urandom_range(N_SLOTS - 1),
					(c < 2) ? 0 : (c < 5) ? $urandom_range(16'hFFFF)
						: $urandom_range(12, 1),
					($urandom_range(6) == 0) ? $urandom_range(16'hFFFF)
						: $urandom_range(10));
			end else begin
				queue_req(CMD_TICK, $urandom_range(255), $urandom_range(16'hFFFF),
					$urandom_range(16'hFFFF));
			end
		end
		total_reqs = pending_reqs.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_taken < total_reqs)
			@(posedge clk);
		while (awaited_reports.size() > 0)
			@(posedge clk);
		// allow slack to catch stray beats
		repeat (40) @(posedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
